>>> design/mwcc_pkg.sv
// shared types, register indexes and pipeline constants for the
// multichannel window color compositor; no dependencies
package mwcc_pkg;

  localparam int MAX_CH         = 4;
  localparam int SAMPLE_W       = 16;
  localparam int COEF_W         = 17;
  localparam int DIV_STAGES     = 4;
  localparam int DIV_BITS       = 4;
  localparam int PIPE_DEPTH     = DIV_STAGES + 6;
  localparam int NUM_CH_DEF     = 4;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 57;

  localparam logic [CFG_IDX_W-1:0] CFG_CHAN0         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN1         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN2         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN3         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_ALPHA  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_CHANNEL = 3'd5;

  localparam logic [7:0]  GA_RESET  = 8'd255;
  localparam logic [2:0]  ACH_RESET = 3'd4;

  typedef struct packed {
    logic        en;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] win_high;
    logic [15:0] win_low;
  } chan_setup_t;

  typedef struct packed {
    logic [15:0] sample_ch0;
    logic [15:0] sample_ch1;
    logic [15:0] sample_ch2;
    logic [15:0] sample_ch3;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } out_word_t;

  // merge mode; the user must keep it static while words are in flight, the block does not enforce it
  typedef struct packed {
    logic       alpha_mode;
    logic       any_en;
    logic [1:0] alpha_idx;
  } blend_mode_t;

endpackage

>>> design/multichannel_window_color_compositor.sv
// top level of the multichannel window color compositor: config registers,
// valid chain and stall control; uses mwcc_pkg, mwcc_window, mwcc_blend
//
// one pixel word (four samples) in, one rgba word out, one word per clock
// sustained unless the output stalls; stages: window front, four divider stages
// of four quotient bits each, rounding, color scale, max merge, premultiply
// product and the divide by 255 into the output register. the whole pipe advances
// together: it moves whenever the output register is empty or being taken,
// so a stalled output holds every stage and nothing is lost or repeated.
// configuration registers are written by index with no handshake and are read
// live by every stage, so write them only while the pipe is empty.
module multichannel_window_color_compositor #(
  parameter int NUM_CHANNELS = mwcc_pkg::NUM_CH_DEF,
  parameter int SAMPLE_BITS  = mwcc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  mwcc_pkg::in_word_t                in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output mwcc_pkg::out_word_t               out_word_o,
  input  logic                              cfg_we_i,
  input  logic [mwcc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mwcc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int NC  = mwcc_pkg::MAX_CH;
  localparam int LAT = mwcc_pkg::PIPE_DEPTH;

  // configuration registers
  mwcc_pkg::chan_setup_t setup_q [NC];
  logic [7:0]            ga_q;
  logic [2:0]            ach_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NC; c++) begin
        setup_q[c] <= '0;
      end
      ga_q  <= mwcc_pkg::GA_RESET;
      ach_q <= mwcc_pkg::ACH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mwcc_pkg::CFG_CHAN0:         setup_q[0] <= mwcc_pkg::chan_setup_t'(cfg_data_i);
        mwcc_pkg::CFG_CHAN1:         setup_q[1] <= mwcc_pkg::chan_setup_t'(cfg_data_i);
        mwcc_pkg::CFG_CHAN2:         setup_q[2] <= mwcc_pkg::chan_setup_t'(cfg_data_i);
        mwcc_pkg::CFG_CHAN3:         setup_q[3] <= mwcc_pkg::chan_setup_t'(cfg_data_i);
        mwcc_pkg::CFG_GLOBAL_ALPHA:  ga_q  <= cfg_data_i[7:0];
        mwcc_pkg::CFG_ALPHA_CHANNEL: ach_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // channels beyond NUM_CHANNELS are seen as disabled
  mwcc_pkg::chan_setup_t eff_setup [NC];
  logic [mwcc_pkg::SAMPLE_W-1:0] samp [NC];
  logic [mwcc_pkg::COEF_W-1:0]   coef [NC];

  assign samp[0] = in_word_i.sample_ch0;
  assign samp[1] = in_word_i.sample_ch1;
  assign samp[2] = in_word_i.sample_ch2;
  assign samp[3] = in_word_i.sample_ch3;

  // pipe control
  logic [LAT-1:0] vld_q;
  logic           adv;

  assign adv        = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  for (genvar c = 0; c < NC; c++) begin : g_ch
    if (c < NUM_CHANNELS) begin : g_on
      assign eff_setup[c] = setup_q[c];
      mwcc_window #(
        .SAMPLE_BITS (SAMPLE_BITS)
      ) u_window (
        .clk_i    (clk_i),
        .en_i     (adv),
        .setup_i  (setup_q[c]),
        .sample_i (samp[c]),
        .coef_o   (coef[c])
      );
    end else begin : g_off
      assign eff_setup[c] = '0;
      assign coef[c]      = '0;
    end
  end

  // merge mode from the live registers
  mwcc_pkg::blend_mode_t mode;
  logic                  any_en;

  always_comb begin
    any_en = 1'b0;
    for (int c = 0; c < NC; c++) begin
      any_en = any_en | eff_setup[c].en;
    end
    mode.any_en     = any_en;
    mode.alpha_idx  = ach_q[1:0];
    mode.alpha_mode = (ach_q < 3'(NC)) && eff_setup[ach_q[1:0]].en;
  end

  mwcc_blend u_blend (
    .clk_i   (clk_i),
    .en_i    (adv),
    .coef_i  (coef),
    .setup_i (eff_setup),
    .ga_i    (ga_q),
    .mode_i  (mode),
    .res_o   (out_word_o)
  );

  assign out_valid_o = vld_q[LAT-1];

`ifndef SYNTHESIS
  // a held output word freezes the whole pipe
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while output stalled");

  // nothing enabled gives a black transparent pixel
  a_none_enabled_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !mode.any_en) |-> (out_word_o == '0))
    else $error("output not zero with no channel enabled");

  // without an alpha channel the alpha is the global alpha
  a_plain_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mode.any_en && !mode.alpha_mode) |-> (out_word_o.alpha == ga_q))
    else $error("alpha differs from global alpha");

  // an accepted word sets the valid bit at the pipe entry when the output is empty
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !vld_q[LAT-1]) |=> vld_q[0])
    else $error("accepted word lost at pipe entry");
`endif

endmodule

>>> design/mwcc_window.sv
// per-channel window: sample to unsigned q1.16 fraction through a
// pipelined long divider; uses mwcc_pkg
module mwcc_window #(
  parameter int SAMPLE_BITS = mwcc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  mwcc_pkg::chan_setup_t       setup_i,
  input  logic [mwcc_pkg::SAMPLE_W-1:0] sample_i,
  output logic [mwcc_pkg::COEF_W-1:0]   coef_o
);

  localparam int SW = mwcc_pkg::SAMPLE_W;
  localparam int NS = mwcc_pkg::DIV_STAGES;
  localparam int NB = mwcc_pkg::DIV_BITS;
  localparam logic [SW-1:0] SampleMask = SW'((33'd1 << SAMPLE_BITS) - 33'd1);

  logic [SW-1:0] rem_q   [0:NS];
  logic [SW-1:0] wid_q   [0:NS];
  logic [SW-1:0] quo_q   [0:NS];
  logic          below_q [0:NS];
  logic          sat_q   [0:NS];

  logic [SW-1:0] v, d, w;
  logic          below, sat;

  // window front: width, offset and saturation flags
  always_comb begin
    v     = sample_i & SampleMask;
    w     = (setup_i.win_high > setup_i.win_low) ?
            (setup_i.win_high - setup_i.win_low) : SW'(1);
    below = (v <= setup_i.win_low);
    d     = v - setup_i.win_low;
    sat   = !below && (d >= w);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]   <= d;
      wid_q[0]   <= w;
      quo_q[0]   <= '0;
      below_q[0] <= below;
      sat_q[0]   <= sat;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_div
    logic [SW-1:0] r_nx, q_nx;
    always_comb begin
      logic [SW:0] rr;
      r_nx = rem_q[s];
      q_nx = quo_q[s];
      for (int b = 0; b < NB; b++) begin
        rr = {r_nx, 1'b0};
        if (rr >= {1'b0, wid_q[s]}) begin
          rr   = rr - {1'b0, wid_q[s]};
          q_nx = {q_nx[SW-2:0], 1'b1};
        end else begin
          q_nx = {q_nx[SW-2:0], 1'b0};
        end
        r_nx = rr[SW-1:0];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]   <= r_nx;
        quo_q[s+1]   <= q_nx;
        wid_q[s+1]   <= wid_q[s];
        below_q[s+1] <= below_q[s];
        sat_q[s+1]   <= sat_q[s];
      end
    end
  end

  // round half up on the remainder, then the clamp cases
  logic [SW:0]              half_sum;
  logic [mwcc_pkg::COEF_W-1:0] coef_d, coef_q;

  always_comb begin
    half_sum = {1'b0, rem_q[NS]} + {2'b0, wid_q[NS][SW-1:1]};
    if (below_q[NS]) begin
      coef_d = '0;
    end else if (sat_q[NS]) begin
      coef_d = mwcc_pkg::COEF_W'(1) << SW;
    end else begin
      coef_d = {1'b0, quo_q[NS]} +
               mwcc_pkg::COEF_W'(half_sum >= {1'b0, wid_q[NS]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

>>> design/mwcc_blend.sv
// color scale, max merge, alpha and premultiply stages
// uses mwcc_pkg; fed by the mwcc_window coefficients
module mwcc_blend (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [mwcc_pkg::COEF_W-1:0]   coef_i  [mwcc_pkg::MAX_CH],
  input  mwcc_pkg::chan_setup_t         setup_i [mwcc_pkg::MAX_CH],
  input  logic [7:0]                    ga_i,
  input  mwcc_pkg::blend_mode_t         mode_i,
  output mwcc_pkg::out_word_t           res_o
);

  localparam int NC = mwcc_pkg::MAX_CH;

  // stage a: scale colors, alpha product
  logic [7:0]  sc_q [NC][3];
  logic [24:0] prod_a_q;

  for (genvar c = 0; c < NC; c++) begin : g_scale
    logic [7:0] col [3];
    logic [7:0] sc  [3];
    assign col[0] = setup_i[c].red;
    assign col[1] = setup_i[c].green;
    assign col[2] = setup_i[c].blue;
    for (genvar k = 0; k < 3; k++) begin : g_comp
      logic [25:0] m;
      assign m      = 26'(col[k]) * 26'(coef_i[c]) + 26'd32768;
      assign sc[k]  = m[23:16];
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          sc_q[c][k] <= sc[k];
        end
      end
    end
  end

  logic [mwcc_pkg::COEF_W-1:0] acoef;
  assign acoef = mode_i.alpha_mode ? coef_i[mode_i.alpha_idx] : '0;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_a_q <= 25'(acoef) * 25'(ga_i);
    end
  end

  // stage b: per-component max and output alpha
  logic [7:0]  rgb_d [3];
  logic [7:0]  rgb_b_q [3];
  logic [7:0]  aout_d, aout_b_q;
  logic [24:0] prod_b_q;
  logic [25:0] a_round;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rgb_d[k] = '0;
      for (int c = 0; c < NC; c++) begin
        if (setup_i[c].en &&
            !(mode_i.alpha_mode && (mode_i.alpha_idx == 2'(c))) &&
            (sc_q[c][k] > rgb_d[k])) begin
          rgb_d[k] = sc_q[c][k];
        end
      end
    end
    a_round = 26'(prod_a_q) + 26'd32768;
    if (mode_i.alpha_mode) begin
      aout_d = a_round[23:16];
    end else begin
      aout_d = mode_i.any_en ? ga_i : 8'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rgb_b_q  <= rgb_d;
      aout_b_q <= aout_d;
      prod_b_q <= prod_a_q;
    end
  end

  // stage c: premultiply product with the rounding offset
  logic [31:0] x_c_q [3];
  logic [7:0]  rgb_c_q [3];
  logic [7:0]  aout_c_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        x_c_q[k] <= 32'(rgb_b_q[k]) * 32'(prod_b_q) + 32'd8355840;
      end
      rgb_c_q  <= rgb_b_q;
      aout_c_q <= aout_b_q;
    end
  end

  // stage d: divide by 255 * 65536 via shift, reciprocal and one correction
  logic [7:0] pm [3];

  always_comb begin
    logic [15:0] y;
    logic [24:0] t;
    logic [8:0]  q0;
    logic [16:0] rem;
    logic [8:0]  p;
    for (int k = 0; k < 3; k++) begin
      y   = x_c_q[k][31:16];
      t   = {1'b0, y, 8'b0} + 25'(y);
      q0  = t[24:16];
      rem = 17'(y) - ({q0, 8'b0} - 17'(q0));
      p   = q0 + 9'(rem >= 17'd255);
      pm[k] = p[8] ? 8'd255 : p[7:0];
    end
  end

  mwcc_pkg::out_word_t res_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.red   <= mode_i.alpha_mode ? pm[0] : rgb_c_q[0];
      res_q.green <= mode_i.alpha_mode ? pm[1] : rgb_c_q[1];
      res_q.blue  <= mode_i.alpha_mode ? pm[2] : rgb_c_q[2];
      res_q.alpha <= aout_c_q;
    end
  end

  assign res_o = res_q;

endmodule
